>>> rtl/core/sst_pkg.sv
// Shared types and constants for the sparse set table.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
`default_nettype none

package sst_pkg;

   localparam int MAX_ENTITIES  = 1024;
   localparam int CAPACITY      = 256;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int ID_W     = $clog2(MAX_ENTITIES);
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;

   // stream packing
   localparam int REQ_FIELDS_W = ID_W + PAYLOAD_WIDTH;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 1 + PAYLOAD_WIDTH + COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_CONTAINS = 3'd2,
      OP_GET      = 3'd3,
      OP_CLEAR    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_PRESENT = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_FULL    = 3'd3,
      ST_RANGE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_CHECK,
      S_MOVE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_step;  // zero one sparse entry of the power-up sweep
      logic capture;   // take request, read sparse map at its id
      logic rd_slot;   // read dense arrays at the looked-up slot
      logic rd_last;   // read dense arrays at the last live slot
      logic finish;    // apply the operation and load the response
      logic move;      // write moved entry back, repoint its id, respond
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic need_move;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/core/sst_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/sst_ctrl.sv
// Sequencer for the sparse set table: power-up sweep, lookup, check, move.
// Depends on sst_pkg.
`default_nettype none

module sst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire sst_pkg::sts_type  sts,
   output sst_pkg::cmd_type       cmd
);

   sst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sst_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = sst_pkg::S_IDLE;
            end
         end
         sst_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sst_pkg::S_LOOKUP;
            end
         end
         sst_pkg::S_LOOKUP: begin
            cmd.rd_slot = 1'b1;
            state_in    = sst_pkg::S_CHECK;
         end
         sst_pkg::S_CHECK: begin
            priority if (sts.need_move) begin
               cmd.rd_last = 1'b1;
               state_in    = sst_pkg::S_MOVE;
            end else if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = sst_pkg::S_IDLE;
            end else begin
               // result register still occupied: wait here
               state_in = sst_pkg::S_CHECK;
            end
         end
         sst_pkg::S_MOVE: begin
            if (sts.out_free) begin
               cmd.move = 1'b1;
               state_in = sst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/sst_datapath.sv
// Datapath: sparse map and dense arrays, live count, membership back-check
// and the response register. Depends on sst_pkg and sst_ram.
`default_nettype none

module sst_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sst_pkg::cmd_type                 cmd,
   output sst_pkg::sts_type                      sts,
   input  wire logic [sst_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [sst_pkg::MODE_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [sst_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int ID_W    = sst_pkg::ID_W;
   localparam int SLOT_W  = sst_pkg::SLOT_W;
   localparam int COUNT_W = sst_pkg::COUNT_W;
   localparam int PW      = sst_pkg::PAYLOAD_WIDTH;

   // captured request
   logic [sst_pkg::MODE_W-1:0] mode_ff;
   logic [ID_W-1:0]            id_ff;
   logic [PW-1:0]              pay_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]    clr_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   sst_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [PW-1:0]          rsp_pay_ff, rsp_pay_in;
   logic [COUNT_W-1:0]     rsp_count_ff;

   // memory ports
   logic              sp_wr_en, sp_rd_en;
   logic [ID_W-1:0]   sp_wr_addr;
   logic [SLOT_W-1:0] sp_wr_data, sp_rd_data;
   logic              dn_wr_en, dn_rd_en;
   logic [SLOT_W-1:0] dn_wr_addr, dn_rd_addr;
   logic [PW-1:0]     pay_wr_data, pay_rd_data;
   logic [ID_W-1:0]   own_wr_data, own_rd_data;

   sst_pkg::op_type   op;
   logic [SLOT_W-1:0] slot, last_slot;
   logic              in_range, member, full, ins_wr;

   assign op        = sst_pkg::op_type'(mode_ff);
   assign slot      = sp_rd_data;
   assign last_slot = SLOT_W'(count_ff - COUNT_W'(1));
   assign in_range  = int'(id_ff) < sst_pkg::MAX_ENTITIES;
   assign full      = count_ff >= COUNT_W'(sst_pkg::CAPACITY);
   // back-check: slot lies in the live region and is owned by this id
   assign member    = in_range && ({1'b0, slot} < count_ff) && (own_rd_data == id_ff);
   assign ins_wr    = cmd.finish && (op == sst_pkg::OP_INSERT) && in_range && !member && !full;

   assign sts.clr_last  = (clr_ff == {ID_W{1'b1}});
   assign sts.need_move = (op == sst_pkg::OP_REMOVE) && member && (slot != last_slot);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   // sparse map port
   assign sp_rd_en = cmd.capture;
   assign sp_wr_en = cmd.clr_step || ins_wr || cmd.move;
   always_comb begin
      priority if (cmd.clr_step) begin
         sp_wr_addr = clr_ff;
         sp_wr_data = '0;
      end else if (cmd.move) begin
         sp_wr_addr = own_rd_data;   // id of the entry moved down
         sp_wr_data = slot;
      end else begin
         sp_wr_addr = id_ff;
         sp_wr_data = count_ff[SLOT_W-1:0];
      end
   end

   // dense arrays share addressing
   assign dn_rd_en   = cmd.rd_slot || cmd.rd_last;
   assign dn_rd_addr = cmd.rd_last ? last_slot : slot;
   assign dn_wr_en   = ins_wr || cmd.move;
   assign dn_wr_addr  = cmd.move ? slot : count_ff[SLOT_W-1:0];
   assign pay_wr_data = cmd.move ? pay_rd_data : pay_ff;
   assign own_wr_data = cmd.move ? own_rd_data : id_ff;

   sst_ram #(.WIDTH(SLOT_W), .DEPTH(sst_pkg::MAX_ENTITIES)) u_sparse (
      .clock   (clock),
      .wr_en   (sp_wr_en),
      .wr_addr (sp_wr_addr),
      .wr_data (sp_wr_data),
      .rd_en   (sp_rd_en),
      .rd_addr (req_tdata[ID_W-1:0]),
      .rd_data (sp_rd_data)
   );

   sst_ram #(.WIDTH(PW), .DEPTH(sst_pkg::CAPACITY)) u_dense_pay (
      .clock   (clock),
      .wr_en   (dn_wr_en),
      .wr_addr (dn_wr_addr),
      .wr_data (pay_wr_data),
      .rd_en   (dn_rd_en),
      .rd_addr (dn_rd_addr),
      .rd_data (pay_rd_data)
   );

   sst_ram #(.WIDTH(ID_W), .DEPTH(sst_pkg::CAPACITY)) u_dense_own (
      .clock   (clock),
      .wr_en   (dn_wr_en),
      .wr_addr (dn_wr_addr),
      .wr_data (own_wr_data),
      .rd_en   (dn_rd_en),
      .rd_addr (dn_rd_addr),
      .rd_data (own_rd_data)
   );

   // operation result
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = sst_pkg::ST_OK;
      rsp_found_in  = member;
      rsp_pay_in    = '0;
      if (cmd.move) begin
         rsp_found_in = 1'b1;
         count_in     = count_ff - COUNT_W'(1);
      end else if (cmd.finish) begin
         if (!in_range && (mode_ff <= sst_pkg::MODE_W'(sst_pkg::OP_GET))) begin
            rsp_status_in = sst_pkg::ST_RANGE;
         end else begin
            unique case (op)
               sst_pkg::OP_INSERT: begin
                  priority if (member) begin
                     rsp_status_in = sst_pkg::ST_PRESENT;
                  end else if (full) begin
                     rsp_status_in = sst_pkg::ST_FULL;
                  end else begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
               sst_pkg::OP_REMOVE: begin
                  // member here means last slot: no move needed
                  if (!member) begin
                     rsp_status_in = sst_pkg::ST_ABSENT;
                  end else begin
                     count_in = count_ff - COUNT_W'(1);
                  end
               end
               sst_pkg::OP_CONTAINS: begin
                  if (!member) begin
                     rsp_status_in = sst_pkg::ST_ABSENT;
                  end
               end
               sst_pkg::OP_GET: begin
                  if (!member) begin
                     rsp_status_in = sst_pkg::ST_ABSENT;
                  end else begin
                     rsp_pay_in = pay_rd_data;
                  end
               end
               sst_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish || cmd.move) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + ID_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tuser;
         id_ff   <= req_tdata[ID_W-1:0];
         pay_ff  <= req_tdata[ID_W +: PW];
      end
      if (cmd.finish || cmd.move) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sst_pkg::RSP_DATA_W'({rsp_count_ff, rsp_pay_ff, rsp_found_ff,
                                             rsp_status_ff});

endmodule

`default_nettype wire

>>> rtl/core/sparse_set_table_top.sv
// Sparse set table keyed by entity id, with swap-remove. A request passes through the
// chain of registered-read memories: sparse map read, dense read, then writes; a remove
// that has to move the last entry down adds a read of the last live slot and a write-back.
// One request is in flight at a time; the result register lets the next request be taken
// while a result waits. After reset the sparse map is swept to zero, during which
// req_tready stays low.
// Top level: instantiates sst_ctrl and sst_datapath; depends on sst_pkg.
`default_nettype none

module sparse_set_table_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [9:0] entity_id, [41:10] payload_in, rest zero
   input  wire logic [sst_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] mode
   input  wire logic [sst_pkg::MODE_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [2:0] status, [3] found, [35:4] payload_out, [44:36] element_count, rest zero
   output logic      [sst_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   sst_pkg::cmd_type cmd;
   sst_pkg::sts_type sts;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/core/sst_checker.sv
// Port-level checks for the sparse set table, bound to the top level.
// Depends on sst_pkg.
`default_nettype none

module sst_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [sst_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int PW = sst_pkg::PAYLOAD_WIDTH;
   localparam int CW = sst_pkg::COUNT_W;

   logic [2:0]    status;
   logic          found;
   logic [PW-1:0] pay;
   logic [CW-1:0] count;

   assign status = rsp_tdata[2:0];
   assign found  = rsp_tdata[3];
   assign pay    = rsp_tdata[4 +: PW];
   assign count  = rsp_tdata[4 + PW +: CW];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count <= CW'(sst_pkg::CAPACITY))
      else $error("element count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == sst_pkg::ST_FULL |-> count == CW'(sst_pkg::CAPACITY) && !found)
      else $error("set full reported below capacity");

   a_pay_only_get: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && pay != '0 |-> status == sst_pkg::ST_OK && found)
      else $error("payload returned without a hit");

   a_absent_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == sst_pkg::ST_ABSENT || status == sst_pkg::ST_PRESENT)
      |-> found == (status == sst_pkg::ST_PRESENT))
      else $error("found flag disagrees with status");

endmodule

bind sparse_set_table_top sst_checker u_sst_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for sparse_set_table_top: insert, swap-remove, lookup and clear traffic
// checked against an in-bench model of the set. Depends on sst_pkg and the RTL top.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int MAX_WAIT      = 18;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;

   // modes 5..7 are not operations; the block answers them with membership only
   localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

   localparam int FOUND_BIT = STATUS_W;
   localparam int PAY_LSB   = STATUS_W + 1;
   localparam int COUNT_LSB = PAY_LSB + PAYLOAD_WIDTH;

   typedef struct {
      logic [MODE_W-1:0]        mode;
      logic [ID_W-1:0]          id;
      logic [PAYLOAD_WIDTH-1:0] data;
      int                       gap;
      bit                       drain;  // wait for all responses before offering
   } request_item;

   typedef struct {
      status_type               status;
      logic                     found;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [COUNT_W-1:0]       count;
   } set_response;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   always #2 clock = ~clock;

   sparse_set_table_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // model of the set
   logic [SLOT_W-1:0]        slot_of_id   [MAX_ENTITIES];
   logic [PAYLOAD_WIDTH-1:0] slot_payload [CAPACITY];
   logic [ID_W-1:0]          slot_owner   [CAPACITY];
   int                       set_size = 0;

   request_item work_items[$];
   set_response due_responses[$];
   request_item next_item;
   set_response want;

   int num_offered = 0;
   int num_accepted = 0;
   int num_responses = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_start = 0;
   int gap_waited = 0;
   int op_tally[8];
   int full_rejects = 0;
   int swap_moves = 0;
   int peak_size = 0;

   function automatic set_response set_table_outcome(logic [MODE_W-1:0] mode,
                                                     logic [ID_W-1:0] id,
                                                     logic [PAYLOAD_WIDTH-1:0] data);
      set_response r;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] last;
      bit in_range;
      bit member;
      in_range = int'(id) < MAX_ENTITIES;
      slot = slot_of_id[id];
      // back-check: slot must be live and owned by this id
      member = in_range && int'(slot) < set_size && slot_owner[slot] == id;
      r.status = ST_OK;
      r.found = member;
      r.payload = '0;
      op_tally[mode]++;
      if (mode <= OP_GET && !in_range) begin
         r.status = ST_RANGE;
      end else begin
         case (mode)
            OP_INSERT: begin
               if (member) begin
                  r.status = ST_PRESENT;
               end else if (set_size >= CAPACITY) begin
                  r.status = ST_FULL;
                  full_rejects++;
               end else begin
                  slot_of_id[id] = SLOT_W'(set_size);
                  slot_payload[set_size] = data;
                  slot_owner[set_size] = id;
                  set_size++;
               end
            end
            OP_REMOVE: begin
               if (!member) begin
                  r.status = ST_ABSENT;
               end else begin
                  last = SLOT_W'(set_size - 1);
                  if (slot != last) begin
                     slot_payload[slot] = slot_payload[last];
                     slot_owner[slot] = slot_owner[last];
                     slot_of_id[slot_owner[slot]] = slot;
                     swap_moves++;
                  end
                  set_size--;
               end
            end
            OP_CONTAINS: begin
               if (!member) r.status = ST_ABSENT;
            end
            OP_GET: begin
               if (!member) r.status = ST_ABSENT;
               else r.payload = slot_payload[slot];
            end
            OP_CLEAR: begin
               set_size = 0;
            end
            default: ;
         endcase
      end
      if (set_size > peak_size) peak_size = set_size;
      r.count = COUNT_W'(set_size);
      return r;
   endfunction

   task automatic compare_field(string what, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t mismatch in %s: expected %0h, actual %0h", $time, what, want_v, got_v);
         mismatch_count++;
      end
   endtask

   task automatic add_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                           logic [PAYLOAD_WIDTH-1:0] data, int gap, bit drain);
      request_item it;
      it.mode = mode;
      it.id = id;
      it.data = data;
      it.gap = gap;
      it.drain = drain;
      work_items.push_back(it);
   endtask

   // style 0: back to back, 1: full random, 2: mostly back to back
   function automatic int pick_gap(int style);
      if (style == 0) return 0;
      if (style == 1) return $urandom_range(0, MAX_WAIT);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(int clear_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < clear_pct) return OP_CLEAR;
      if (r < clear_pct + 3) return MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
      if (r < 40) return OP_INSERT;
      if (r < 63) return OP_REMOVE;
      if (r < 78) return OP_CONTAINS;
      return OP_GET;
   endfunction

   // request side: per-transfer gap, optional drain, valid held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_waited = 0;
      end else if (req_tvalid && num_accepted != num_offered) begin
         // transfer still pending
      end else if (work_items.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (gap_waited < work_items[0].gap ||
                   (work_items[0].drain && due_responses.size() != 0)) begin
         gap_waited++;
         req_tvalid <= 1'b0;
      end else begin
         next_item = work_items.pop_front();
         req_tuser <= next_item.mode;
         req_tdata <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, next_item.data, next_item.id};
         req_tvalid <= 1'b1;
         num_offered++;
         gap_waited = 0;
      end
   end

   // response side: stall per transfer, one long hold-off while the burst arrives
   int  rx_seen = 0;
   int  rx_wait = 0;
   int  rx_hold = 0;
   bit  hold_used = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_used && num_accepted > burst_start) begin
            hold_used = 1'b1;
            rx_hold = HOLD_CYCLES;
         end
         if (num_responses != rx_seen) begin
            rx_seen = num_responses;
            // every third stretch of 150 responses runs without stalls
            if ((rx_seen / 150) % 3 == 1 || $urandom_range(0, 1) == 0) rx_wait = 0;
            else rx_wait = $urandom_range(0, MAX_WAIT);
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // responses checked before the same edge's request is modeled
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            num_responses++;
            if (due_responses.size() == 0) begin
               $display("%0t unexpected response: expected none, actual %0h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = due_responses.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_tdata[STATUS_W-1:0]));
               compare_field("found", 64'(want.found), 64'(rsp_tdata[FOUND_BIT]));
               compare_field("payload_out", 64'(want.payload),
                             64'(rsp_tdata[PAY_LSB +: PAYLOAD_WIDTH]));
               compare_field("element_count", 64'(want.count),
                             64'(rsp_tdata[COUNT_LSB +: COUNT_W]));
            end
         end
         if (req_tvalid && req_tready) begin
            due_responses.push_back(set_table_outcome(req_tuser, req_tdata[ID_W-1:0],
                                                      req_tdata[ID_W +: PAYLOAD_WIDTH]));
            num_accepted++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_responses.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   logic [ID_W-1:0] id_pool[$];
   logic [ID_W-1:0] order[MAX_ENTITIES];
   logic [ID_W-1:0] tmp_id;
   int style;
   int j;

   initial begin
      for (int i = 0; i < MAX_ENTITIES; i++) slot_of_id[i] = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_payload[i] = '0;
         slot_owner[i] = '0;
      end
      for (int i = 0; i < 8; i++) op_tally[i] = 0;

      // directed: empty set, extremes, swap paths, stale entries, reserved modes
      add_item(OP_CONTAINS, 10'd0, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_GET, 10'd0, 32'hFFFF_FFFF, pick_gap(1), 1'b0);
      add_item(OP_REMOVE, 10'd1023, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_INSERT, 10'd0, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_INSERT, 10'd1023, 32'hFFFF_FFFF, pick_gap(1), 1'b0);
      add_item(OP_INSERT, 10'd0, 32'h1234_5678, pick_gap(1), 1'b0);
      add_item(OP_GET, 10'd0, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_GET, 10'd1023, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_CONTAINS, 10'd1023, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_INSERT, 10'd512, 32'hA5A5_5A5A, pick_gap(1), 1'b0);
      add_item(OP_REMOVE, 10'd0, 32'h0, pick_gap(1), 1'b0);        // last entry moves down
      add_item(OP_GET, 10'd512, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_CONTAINS, 10'd0, 32'h0, pick_gap(1), 1'b0);      // stale sparse entry
      add_item(OP_REMOVE, 10'd512, 32'h0, pick_gap(1), 1'b0);
      add_item(OP_REMOVE, 10'd1023, 32'h0, pick_gap(1), 1'b0);     // removes the last slot
      add_item(OP_INSERT, 10'd341, 32'h5555_5555, pick_gap(1), 1'b0);
      add_item(OP_CLEAR, 10'd341, 32'hFFFF_FFFF, pick_gap(1), 1'b0);
      add_item(OP_CONTAINS, 10'd341, 32'h0, pick_gap(1), 1'b0);    // stale after clear
      add_item(OP_INSERT, 10'd682, 32'hAAAA_AAAA, pick_gap(1), 1'b0);
      add_item(3'd5, 10'd682, 32'h0, pick_gap(1), 1'b0);
      add_item(3'd6, 10'd341, 32'h0, pick_gap(1), 1'b0);
      add_item(MODE_RSVD_HI, 10'd1023, 32'hFFFF_FFFF, pick_gap(1), 1'b0);
      add_item(OP_CLEAR, 10'd682, 32'h0, pick_gap(1), 1'b0);

      // a small id pool keeps hits frequent
      id_pool.push_back(10'd0);
      id_pool.push_back(10'd1023);
      for (int i = 0; i < 18; i++) id_pool.push_back(ID_W'($urandom_range(0, 1023)));

      style = 1;
      for (int k = 0; k < 600; k++) begin
         if (k % 100 == 0) style = $urandom_range(0, 2);
         add_item(pick_mode(1), id_pool[$urandom_range(0, id_pool.size() - 1)], $urandom,
                  pick_gap(style), $urandom_range(0, 149) == 0);
      end

      // burst: starts from an empty pipeline, receiver holds off meanwhile
      burst_start = work_items.size();
      for (int k = 0; k < 60; k++)
         add_item(pick_mode(1), id_pool[$urandom_range(0, id_pool.size() - 1)], $urandom,
                  0, k == 0);

      // fill to capacity with distinct ids, then overflow
      for (int i = 0; i < MAX_ENTITIES; i++) order[i] = ID_W'(i);
      for (int i = MAX_ENTITIES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp_id = order[i];
         order[i] = order[j];
         order[j] = tmp_id;
      end
      add_item(OP_CLEAR, ID_W'($urandom_range(0, 1023)), $urandom, pick_gap(1), 1'b1);
      for (int k = 0; k < CAPACITY + 14; k++) begin
         if (k % 90 == 0) style = $urandom_range(0, 2);
         add_item(OP_INSERT, order[k], $urandom, pick_gap(style), 1'b0);
      end

      // churn near full
      for (int k = 0; k < 300; k++) begin
         if (k % 100 == 0) style = $urandom_range(0, 2);
         add_item(pick_mode(0), order[$urandom_range(0, CAPACITY + 43)], $urandom,
                  pick_gap(style), 1'b0);
      end

      // wide ids, more clears
      for (int k = 0; k < 400; k++) begin
         if (k % 100 == 0) style = $urandom_range(0, 2);
         tmp_id = $urandom_range(0, 1) ? order[$urandom_range(0, 63)]
                                       : ID_W'($urandom_range(0, 1023));
         add_item(pick_mode(3), tmp_id, $urandom, pick_gap(style),
                  $urandom_range(0, 149) == 0);
      end

      for (int k = 0; k < 150; k++)
         add_item(pick_mode(2), id_pool[$urandom_range(0, id_pool.size() - 1)], $urandom,
                  pick_gap(2), 1'b0);

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (work_items.size() != 0 || num_accepted != num_offered ||
             due_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("%0d requests: insert %0d, remove %0d, contains %0d, get %0d, clear %0d, other %0d",
               num_accepted, op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_CONTAINS],
               op_tally[OP_GET], op_tally[OP_CLEAR], op_tally[5] + op_tally[6] + op_tally[7]);
      $display("full rejections %0d, swap moves %0d, peak occupancy %0d, %0d cycles",
               full_rejects, swap_moves, peak_size, cycle_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
